/* hdl/mmsd_pkg.sv */
// Package with shared types and constants for the motor mode select block.
package mmsd_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_ALARM_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_SOURCE_SELECT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_CONTROL_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_SPEED          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_INPUT_ENABLE = 3'd4;

	// Fire control modes.
	localparam logic [1:0] FIRE_MODE_KEEP    = 2'd0;
	localparam logic [1:0] FIRE_MODE_STOP    = 2'd1;
	localparam logic [1:0] FIRE_MODE_FORWARD = 2'd2;
	localparam logic [1:0] FIRE_MODE_REVERSE = 2'd3;

	// Fire source selection.
	localparam logic FIRE_SRC_PIN    = 1'b0;
	localparam logic FIRE_SRC_REMOTE = 1'b1;

	localparam logic [SPEED_W-1:0] REVERSE_BIT = 16'h8000;

	typedef struct packed {
		logic               fire_alarm_enable;
		logic               fire_source_select;
		logic [1:0]         fire_control_mode;
		logic [SPEED_W-1:0] fire_speed;
		logic               manual_input_enable;
	} cfg_t;

	typedef struct packed {
		logic               motor_run;
		logic               fire_active;
		logic [SPEED_W-1:0] held_speed;
		logic [SPEED_W-1:0] target_speed;
	} dec_t;

endpackage

/* hdl/mmsd_debounce.sv */
// Hold counter that qualifies one raw pin after it stays high long enough.
module mmsd_debounce #(
	parameter int unsigned HOLD_TICKS = 500
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic level,
	output logic valid
);
	localparam int unsigned CW = $clog2(HOLD_TICKS + 1);
	localparam logic [CW-1:0] HOLD = CW'(HOLD_TICKS);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	// Count while high, stop at the hold count, clear when low.
	always_comb begin
		if (!level) begin
			count_d = '0;
		end else if (count_q < HOLD) begin
			count_d = count_q + CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	assign valid = (count_d == HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_d;
		end
	end

endmodule

/* hdl/mmsd_decide.sv */
// Mode decision: fire override, manual run input or free run.
module mmsd_decide (
	input  mmsd_pkg::cfg_t               cfg,
	input  logic                         run_valid,
	input  logic                         fire_valid,
	input  logic                         remote_fire_flag,
	input  logic [mmsd_pkg::SPEED_W-1:0] held_speed,
	input  logic [mmsd_pkg::SPEED_W-1:0] target_speed,
	output mmsd_pkg::dec_t               dec
);
	import mmsd_pkg::*;

	logic fire_on;
	logic [SPEED_W-1:0] held_next;

	assign fire_on = cfg.fire_alarm_enable &&
		((cfg.fire_source_select == FIRE_SRC_PIN && fire_valid) ||
		 (cfg.fire_source_select == FIRE_SRC_REMOTE && remote_fire_flag));

	always_comb begin
		case (cfg.fire_control_mode)
			FIRE_MODE_STOP:    held_next = '0;
			FIRE_MODE_FORWARD: held_next = cfg.fire_speed;
			FIRE_MODE_REVERSE: held_next = cfg.fire_speed | REVERSE_BIT;
			default:           held_next = held_speed;
		endcase
	end

	always_comb begin
		dec.fire_active  = fire_on;
		dec.held_speed   = held_speed;
		dec.target_speed = target_speed;
		if (fire_on) begin
			dec.motor_run    = 1'b0;
			dec.held_speed   = held_next;
			dec.target_speed = held_next;
		end else if (cfg.manual_input_enable) begin
			dec.motor_run = run_valid;
			if (!run_valid) begin
				dec.target_speed = '0;
			end
		end else begin
			dec.motor_run = 1'b1;
		end
	end

endmodule

/* hdl/motor_mode_select_with_input_debounce.sv */
// Top level of the motor mode select block with pin debounce.
//
// One input item on the s_axis channel is one control tick. It carries the
// raw run pin, the raw fire pin and the remote fire flag. Each tick produces
// exactly one result item on the m_axis channel with the run command, the
// fire override flag, the target speed and both pin qualification flags.
//
// The state (two hold counters, the held fire speed and the target speed)
// is updated at the edge that accepts an item, and the result goes into an
// output register, presented in the cycle after the item is accepted. One
// item can be accepted in every cycle while the receiver does not stall.
//
// s_axis_tready is high whenever the output register is empty or its item
// is being taken in the same cycle. When the receiver stalls, the result
// holds in the output register and the block takes no new item until it
// drains; the hold counters and the speeds do not change while stalled.
//
// The configuration port writes one register per cycle with cfg_wr_en high;
// indexes beyond the register list are ignored. Reset clears all configuration registers,
// both hold counters, the speeds and the output valid flag.
module motor_mode_select_with_input_debounce #(
	parameter int unsigned HOLD_TICKS = 500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] run_pin, [1] fire_pin, [2] remote_fire_flag, [7:3] zero
	input  logic [7:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] motor_run, [1] fire_active, [17:2] target_speed,
	// [18] run_pin_valid, [19] fire_pin_valid, [23:20] zero
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import mmsd_pkg::*;

	cfg_t               cfg_q;
	logic [SPEED_W-1:0] held_speed_q;
	logic [SPEED_W-1:0] target_speed_q;
	logic               out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_s1;

	logic accept;
	logic run_valid;
	logic fire_valid;
	dec_t dec;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_FIRE_ALARM_ENABLE:   cfg_q.fire_alarm_enable <= cfg_wdata[0];
				REG_FIRE_SOURCE_SELECT:  cfg_q.fire_source_select <= cfg_wdata[0];
				REG_FIRE_CONTROL_MODE:   cfg_q.fire_control_mode <= cfg_wdata[1:0];
				REG_FIRE_SPEED:          cfg_q.fire_speed <= cfg_wdata[SPEED_W-1:0];
				REG_MANUAL_INPUT_ENABLE: cfg_q.manual_input_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Pin qualification; each counter advances once per accepted item.
	mmsd_debounce #(.HOLD_TICKS(HOLD_TICKS)) u_run_db (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (accept),
		.level (s_axis_tdata[0]),
		.valid (run_valid)
	);

	mmsd_debounce #(.HOLD_TICKS(HOLD_TICKS)) u_fire_db (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (accept),
		.level (s_axis_tdata[1]),
		.valid (fire_valid)
	);

	mmsd_decide u_decide (
		.cfg             (cfg_q),
		.run_valid       (run_valid),
		.fire_valid      (fire_valid),
		.remote_fire_flag(s_axis_tdata[2]),
		.held_speed      (held_speed_q),
		.target_speed    (target_speed_q),
		.dec             (dec)
	);

	// Speed state follows the decision of each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q   <= '0;
			target_speed_q <= '0;
		end else if (accept) begin
			held_speed_q   <= dec.held_speed;
			target_speed_q <= dec.target_speed;
		end
	end

	// Output register: valid flag under reset, payload loaded on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_s1 <= {4'b0000, fire_valid, run_valid, dec.target_speed,
				dec.fire_active, dec.motor_run};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_s1;

endmodule
